FILE: src/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the 4x4 matrix-vector transform
// Transaction payloads, mode codes and configuration register layout.
// ----------------------------------------------------------------------------
package mvt_pkg;

  // Port-level field width of every vector element
  localparam int IO_WIDTH = 32;

  // Parameter defaults
  localparam int DEF_FRAC_BITS     = 16;
  localparam int DEF_ELEMENT_WIDTH = 32;

  // Configuration port layout
  localparam int NUM_REGS    = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int HALF_W      = 32;

  // Mode codes carried in the action field
  localparam logic ACTION_COLUMN = 1'b0;  // M * v
  localparam logic ACTION_ROW    = 1'b1;  // v * M

  // Input transaction
  typedef struct packed {
    logic                       action;
    logic signed [IO_WIDTH-1:0] x_in;
    logic signed [IO_WIDTH-1:0] y_in;
    logic signed [IO_WIDTH-1:0] z_in;
    logic signed [IO_WIDTH-1:0] w_in;
  } mvt_in_t;

  // Result transaction
  typedef struct packed {
    logic signed [IO_WIDTH-1:0] x_out;
    logic signed [IO_WIDTH-1:0] y_out;
    logic signed [IO_WIDTH-1:0] z_out;
    logic signed [IO_WIDTH-1:0] w_out;
    logic                       saturated;
  } mvt_out_t;

endpackage

FILE: src/mvt_cfg_regs.sv
// ----------------------------------------------------------------------------
// mvt_cfg_regs: matrix coefficient store
// Unpacks each 64-bit register write into two matrix elements of one row.
// ----------------------------------------------------------------------------
module mvt_cfg_regs #(
  parameter int ELEMENT_WIDTH = mvt_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [mvt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mvt_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [3:0][3:0][ELEMENT_WIDTH-1:0]   mat
);
  import mvt_pkg::*;

  logic [1:0] row;
  logic [1:0] col_hi;
  logic [1:0] col_lo;
  logic       index_ok;

  // Decode row and column pair from the register index
  assign row      = cfg_index[2:1];
  assign col_hi   = {cfg_index[0], 1'b0};
  assign col_lo   = {cfg_index[0], 1'b1};
  assign index_ok = cfg_index < CFG_INDEX_W'(NUM_REGS);

  // Store elements; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= '0;
    end else if (cfg_write_en && index_ok) begin
      mat[row][col_hi] <= cfg_data[HALF_W +: ELEMENT_WIDTH];
      mat[row][col_lo] <= cfg_data[0 +: ELEMENT_WIDTH];
    end
  end

endmodule

FILE: src/mvt_mult.sv
// ----------------------------------------------------------------------------
// mvt_mult: input register and product stage
// Captures the vector, selects matrix elements by mode, forms 16 products.
// ----------------------------------------------------------------------------
module mvt_mult #(
  parameter int ELEMENT_WIDTH = mvt_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mvt_pkg::mvt_in_t                       in_data,
  input  logic [3:0][3:0][ELEMENT_WIDTH-1:0]     mat,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [3:0][3:0][2*ELEMENT_WIDTH-1:0]   prod
);
  import mvt_pkg::*;

  localparam int PW = 2 * ELEMENT_WIDTH;

  logic                              s0_valid;
  logic                              s0_ready;
  logic                              s0_row;
  logic [3:0][ELEMENT_WIDTH-1:0]     s0_vec;
  logic                              s1_ready;
  logic [3:0][3:0][PW-1:0]           prod_next;

  // Stage handshakes: a stage loads when empty or when its successor moves
  assign s1_ready = !out_valid || out_ready;
  assign s0_ready = !s0_valid || s1_ready;
  assign in_ready = s0_ready;

  // Capture the input transaction, keeping the low element bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_ready) begin
      s0_row    <= (in_data.action == ACTION_ROW);
      s0_vec[0] <= in_data.x_in[ELEMENT_WIDTH-1:0];
      s0_vec[1] <= in_data.y_in[ELEMENT_WIDTH-1:0];
      s0_vec[2] <= in_data.z_in[ELEMENT_WIDTH-1:0];
      s0_vec[3] <= in_data.w_in[ELEMENT_WIDTH-1:0];
    end
  end

  // Select M[i][j] or M[j][i] and multiply by v[j]
  always_comb begin
    logic signed [ELEMENT_WIDTH-1:0] m_el;
    logic signed [ELEMENT_WIDTH-1:0] v_el;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        m_el            = s0_row ? mat[j][i] : mat[i][j];
        v_el            = s0_vec[j];
        prod_next[i][j] = PW'(m_el * v_el);
      end
    end
  end

  // Register the products
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid && s1_ready) begin
      prod <= prod_next;
    end
  end

endmodule

FILE: src/mvt_adder.sv
// ----------------------------------------------------------------------------
// mvt_adder: two-level adder tree and fraction shift
// Sums four products per lane and drops the fraction bits (floor).
// ----------------------------------------------------------------------------
module mvt_adder #(
  parameter int FRAC_BITS     = mvt_pkg::DEF_FRAC_BITS,
  parameter int ELEMENT_WIDTH = mvt_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [3:0][3:0][2*ELEMENT_WIDTH-1:0]   prod,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [3:0][2*ELEMENT_WIDTH+1:0]        sum
);
  localparam int PW = 2 * ELEMENT_WIDTH;
  localparam int SW = PW + 2;

  logic                       a_valid;
  logic                       a_ready;
  logic                       b_ready;
  logic [3:0][1:0][PW:0]      pair;
  logic [3:0][1:0][PW:0]      pair_next;
  logic [3:0][SW-1:0]         sum_next;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // First level: pairwise sums, one guard bit
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pair_next[i][0] = (PW+1)'($signed(prod[i][0])) + (PW+1)'($signed(prod[i][1]));
      pair_next[i][1] = (PW+1)'($signed(prod[i][2])) + (PW+1)'($signed(prod[i][3]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      pair <= pair_next;
    end
  end

  // Second level: lane total, arithmetic shift rounds toward minus infinity
  always_comb begin
    logic signed [SW-1:0] total;
    for (int i = 0; i < 4; i++) begin
      total       = SW'($signed(pair[i][0])) + SW'($signed(pair[i][1]));
      sum_next[i] = total >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      sum <= sum_next;
    end
  end

endmodule

FILE: src/mvt_sat.sv
// ----------------------------------------------------------------------------
// mvt_sat: saturation and output register
// Clips each lane to the signed element range and flags any clip.
// ----------------------------------------------------------------------------
module mvt_sat #(
  parameter int ELEMENT_WIDTH = mvt_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0][2*ELEMENT_WIDTH+1:0]   sum,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mvt_pkg::mvt_out_t                 out_data
);
  import mvt_pkg::*;

  localparam int SW = 2 * ELEMENT_WIDTH + 2;
  localparam logic signed [SW-1:0] EMAX =
    {{(SW-ELEMENT_WIDTH+1){1'b0}}, {(ELEMENT_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] EMIN =
    {{(SW-ELEMENT_WIDTH+1){1'b1}}, {(ELEMENT_WIDTH-1){1'b0}}};

  logic                                 ready;
  logic [3:0][ELEMENT_WIDTH-1:0]        lane;
  logic [3:0]                           clip;
  mvt_out_t                             out_next;

  assign ready    = !out_valid || !out_stall;
  assign in_ready = ready;

  // Clip each lane
  always_comb begin
    logic signed [SW-1:0] s;
    for (int i = 0; i < 4; i++) begin
      s = sum[i];
      if (s > EMAX) begin
        lane[i] = EMAX[ELEMENT_WIDTH-1:0];
        clip[i] = 1'b1;
      end else if (s < EMIN) begin
        lane[i] = EMIN[ELEMENT_WIDTH-1:0];
        clip[i] = 1'b1;
      end else begin
        lane[i] = s[ELEMENT_WIDTH-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  // Sign-extend lanes to the port width
  always_comb begin
    out_next.x_out     = IO_WIDTH'($signed(lane[0]));
    out_next.y_out     = IO_WIDTH'($signed(lane[1]));
    out_next.z_out     = IO_WIDTH'($signed(lane[2]));
    out_next.w_out     = IO_WIDTH'($signed(lane[3]));
    out_next.saturated = |clip;
  end

  // Output register; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready) begin
      out_data <= out_next;
    end
  end

endmodule

FILE: src/matrix_vector_transform_4x4_unit.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_unit: pipelined 4x4 fixed-point transform
// Column mode returns M * v, row mode returns v * M, saturated per element.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  in        input      in_valid / in_stall      mvt_in_t  (action, x..w_in)
//  out       output     out_valid / out_stall    mvt_out_t (x..w_out, saturated)
//  cfg       input      cfg_write_en             cfg_index, cfg_data (64 bits)
//
//  One transaction per cycle while out_stall is low; a result goes through
//  every stage register below before out_valid rises for it.
//  Stages: input register, 32x32 products, pair sums, lane sum and shift,
//  saturation. The product stage sets the clock period.
//  Reset clears all stage valid bits and the matrix to zero.
//  A stall on the output backs up one stage at a time; empty stages still
//  accept, so in_stall rises only when every stage holds a transaction.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_unit #(
  parameter int FRAC_BITS     = mvt_pkg::DEF_FRAC_BITS,
  parameter int ELEMENT_WIDTH = mvt_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mvt_pkg::mvt_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mvt_pkg::mvt_out_t                 out_data,
  input  logic                              cfg_write_en,
  input  logic [mvt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mvt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mvt_pkg::*;

  logic [3:0][3:0][ELEMENT_WIDTH-1:0]     mat;
  logic                                   mult_in_ready;
  logic                                   mult_valid;
  logic                                   add_in_ready;
  logic [3:0][3:0][2*ELEMENT_WIDTH-1:0]   prod;
  logic                                   add_valid;
  logic                                   sat_in_ready;
  logic [3:0][2*ELEMENT_WIDTH+1:0]        sum;

  assign in_stall = !mult_in_ready;

  // Matrix coefficients
  mvt_cfg_regs #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mat          (mat)
  );

  // Input capture and products
  mvt_mult #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (mult_in_ready),
    .in_data   (in_data),
    .mat       (mat),
    .out_valid (mult_valid),
    .out_ready (add_in_ready),
    .prod      (prod)
  );

  // Adder tree and fraction shift
  mvt_adder #(
    .FRAC_BITS     (FRAC_BITS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_adder (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mult_valid),
    .in_ready  (add_in_ready),
    .prod      (prod),
    .out_valid (add_valid),
    .out_ready (sat_in_ready),
    .sum       (sum)
  );

  // Saturation and output register
  mvt_sat #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (add_valid),
    .in_ready  (sat_in_ready),
    .sum       (sum),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/matrix_vector_transform_4x4_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_unit_tb: self-checking bench for the 4x4 transform
// A directed table covers reset state, identity, saturation in both
// directions, floor rounding of negative sums and dropped writes past the
// register file. Random phases load new matrices and stream vectors under
// random idle and stall bursts (the last back to back). Each result is checked
// in order of acceptance against its table value or a local fixed-point predictor.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_unit_tb;
  import mvt_pkg::*;

  localparam int FRAC          = DEF_FRAC_BITS;
  localparam int ELEM_W        = DEF_ELEMENT_WIDTH;
  localparam int PIPE_LATENCY  = 5;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 100;
  localparam int REG_INDEX_TOP = 2 ** CFG_INDEX_W - 1;
  localparam int REG_SEL_W     = $clog2(NUM_REGS);

  localparam logic [31:0]        ONE      = 32'h0001_0000;
  localparam logic signed [67:0] ELEM_MAX = (68'sd1 <<< (ELEM_W - 1)) - 68'sd1;
  localparam logic signed [67:0] ELEM_MIN = -ELEM_MAX - 68'sd1;

  // Register file layout: two elements per 64-bit word
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW0_COLS01, REG_ROW0_COLS23, REG_ROW1_COLS01, REG_ROW1_COLS23,
    REG_ROW2_COLS01, REG_ROW2_COLS23, REG_ROW3_COLS01, REG_ROW3_COLS23
  } reg_index_e;

  typedef enum logic [1:0] {STEP_ITEM, STEP_MATRIX, STEP_WRITE} step_kind_e;
  typedef enum logic [1:0] {MIX_SMALL, MIX_WIDE, MIX_CORNER, MIX_FULL} value_mix_e;

  typedef struct packed {
    step_kind_e             kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    mvt_in_t                item;
    logic                   typed;
    mvt_out_t               result;
  } directed_step_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  mvt_in_t                in_data      = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  mvt_out_t               out_data;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  // Typed expectation that travels alongside the driven transaction
  logic     result_typed = 1'b0;
  mvt_out_t typed_result = '0;

  logic [CFG_DATA_W-1:0] matrix_words [NUM_REGS];
  mvt_out_t              expected_results [$];
  directed_step_t        directed_steps [$];
  reg_write_t            config_writes [$];
  mvt_out_t              head;
  int                    sent_count    = 0;
  int                    results_seen  = 0;
  int                    error_count   = 0;
  int                    cycle_count   = 0;
  logic                  steady        = 1'b0;

  matrix_vector_transform_4x4_unit #(
    .FRAC_BITS    (FRAC),
    .ELEMENT_WIDTH(ELEM_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Keep the low ELEM_W bits of a field, two's complement
  function automatic logic signed [31:0] to_element(logic [31:0] raw);
    logic signed [31:0] t;
    t = raw << (32 - ELEM_W);
    return t >>> (32 - ELEM_W);
  endfunction

  function automatic logic signed [31:0] matrix_elem(int r, int c);
    logic [CFG_DATA_W-1:0] word;
    word = matrix_words[r * 2 + c / 2];
    return to_element((c % 2 == 1) ? word[31:0] : word[63:32]);
  endfunction

  // Exact four-term dot product, floor shift, clip to the element range
  function automatic mvt_out_t transform_vector(mvt_in_t item);
    logic signed [31:0] vec [4];
    logic signed [31:0] lane [4];
    logic signed [31:0] coef;
    logic signed [67:0] acc;
    logic               clipped;
    mvt_out_t           res;
    vec[0] = to_element(item.x_in);
    vec[1] = to_element(item.y_in);
    vec[2] = to_element(item.z_in);
    vec[3] = to_element(item.w_in);
    clipped = 1'b0;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) begin
        coef = (item.action == ACTION_ROW) ? matrix_elem(j, i) : matrix_elem(i, j);
        acc = acc + 68'(coef) * 68'(vec[j]);
      end
      acc = acc >>> FRAC;
      if (acc > ELEM_MAX) begin
        lane[i] = 32'(ELEM_MAX);
        clipped = 1'b1;
      end else if (acc < ELEM_MIN) begin
        lane[i] = 32'(ELEM_MIN);
        clipped = 1'b1;
      end else begin
        lane[i] = 32'(acc);
      end
    end
    res.x_out     = lane[0];
    res.y_out     = lane[1];
    res.z_out     = lane[2];
    res.w_out     = lane[3];
    res.saturated = clipped;
    return res;
  endfunction

  function automatic logic [31:0] rand_element(value_mix_e mix);
    int pick;
    pick = $urandom_range(0, 9);
    if (mix == MIX_SMALL || (mix == MIX_WIDE && pick < 5))
      return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
    if (mix == MIX_WIDE && pick < 7)
      return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
    if (mix == MIX_CORNER || (mix == MIX_WIDE && pick == 7)) begin
      case ($urandom_range(0, 7))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'h0000_0001;
        4: return 32'hFFFF_FFFF;
        5: return ONE;
        6: return 32'hFFFF_0000;
        default: return 32'h0000_8000;
      endcase
    end
    return $urandom();
  endfunction

  // Word of a matrix with one value on the diagonal and another elsewhere
  function automatic logic [CFG_DATA_W-1:0] matrix_word(int index, logic [31:0] diag,
                                                         logic [31:0] off);
    int r;
    int c;
    r = index / 2;
    c = (index % 2) * 2;
    return {(r == c) ? diag : off, (r == c + 1) ? diag : off};
  endfunction

  function automatic mvt_in_t vec_in(logic act, logic [31:0] x, logic [31:0] y,
                                     logic [31:0] z, logic [31:0] w);
    mvt_in_t v;
    v.action = act;
    v.x_in   = x;
    v.y_in   = y;
    v.z_in   = z;
    v.w_in   = w;
    return v;
  endfunction

  function automatic mvt_out_t vec_out(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [31:0] w, logic sat);
    mvt_out_t r;
    r.x_out     = x;
    r.y_out     = y;
    r.z_out     = z;
    r.w_out     = w;
    r.saturated = sat;
    return r;
  endfunction

  function automatic void add_step(step_kind_e kind, logic [CFG_DATA_W-1:0] data,
                                   int index, mvt_in_t item, logic typed, mvt_out_t result);
    directed_step_t s;
    s.kind   = kind;
    s.index  = CFG_INDEX_W'(index);
    s.data   = data;
    s.item   = item;
    s.typed  = typed;
    s.result = result;
    directed_steps.push_back(s);
  endfunction

  function automatic void queue_write(int index, logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.index = CFG_INDEX_W'(index);
    w.data  = data;
    config_writes.push_back(w);
  endfunction

  function automatic void build_directed();
    // Matrix is zero out of reset
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'h7FFF_FFFF, 32'h8000_0000,
             32'hFFFF_FFFF, 32'h0000_0001), 1'b1, vec_out(0, 0, 0, 0, 1'b0));
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_ROW, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0000, 32'hFFFF_FFFF), 1'b1, vec_out(0, 0, 0, 0, 1'b0));
    // Identity passes the vector through in either mode
    add_step(STEP_MATRIX, {ONE, 32'h0}, 0, '0, 1'b0, '0);
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'h7FFF_FFFF, 32'h8000_0000,
             32'hFFFF_FFFF, 32'h0000_0001), 1'b1,
             vec_out(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_ROW, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0000, 32'hFFFF_FFFF), 1'b1,
             vec_out(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
    // Writes past the register file must leave the identity intact
    add_step(STEP_WRITE, '1, NUM_REGS, '0, 1'b0, '0);
    add_step(STEP_WRITE, '1, REG_INDEX_TOP, '0, 1'b0, '0);
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'h0001_0000, 32'hFFFF_0000,
             32'h1234_5678, 32'h8765_4321), 1'b1,
             vec_out(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321, 1'b0));
    // All elements at the positive extreme
    add_step(STEP_MATRIX, {32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, '0, 1'b0, '0);
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
             vec_out(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_ROW, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000), 1'b1,
             vec_out(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 0, 0, 0, 0), 1'b1,
             vec_out(0, 0, 0, 0, 1'b0));
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'h0000_0001, 0, 0, 0), 1'b1,
             vec_out(32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 1'b0));
    // All elements at the negative extreme
    add_step(STEP_MATRIX, {32'h8000_0000, 32'h8000_0000}, 0, '0, 1'b0, '0);
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_ROW, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000), 1'b1,
             vec_out(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
             vec_out(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_ROW, 0, 0, 0, 32'h0000_0001), 1'b1,
             vec_out(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 1'b0));
    // Half on the diagonal: negative sums round toward minus infinity
    add_step(STEP_MATRIX, {32'h0000_8000, 32'h0}, 0, '0, 1'b0, '0);
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
             vec_out(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_ROW, 32'h0000_0001, 32'h0000_0001,
             32'h0000_0001, 32'h0000_0001), 1'b1, vec_out(0, 0, 0, 0, 1'b0));
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'h0002_0000, 32'hFFFE_0000,
             32'h0000_0003, 32'hFFFF_FFFD), 1'b1,
             vec_out(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFE, 1'b0));
    // Asymmetric matrix separates column mode from row mode
    add_step(STEP_MATRIX, {ONE, 32'h0}, 0, '0, 1'b0, '0);
    add_step(STEP_WRITE, {32'h0002_0000, 32'h0003_0000}, REG_ROW0_COLS23, '0, 1'b0, '0);
    add_step(STEP_WRITE, {32'hFFFF_0000, 32'h0000_8000}, REG_ROW3_COLS01, '0, 1'b0, '0);
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'h0001_0000, 32'h0002_0000,
             32'h0003_0000, 32'h0004_0000), 1'b0, '0);
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_ROW, 32'h0001_0000, 32'h0002_0000,
             32'h0003_0000, 32'h0004_0000), 1'b0, '0);
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_COLUMN, 32'hDEAD_BEEF, 32'h0123_4567,
             32'h89AB_CDEF, 32'h7654_3210), 1'b0, '0);
    add_step(STEP_ITEM, '0, 0, vec_in(ACTION_ROW, 32'hDEAD_BEEF, 32'h0123_4567,
             32'h89AB_CDEF, 32'h7654_3210), 1'b0, '0);
  endfunction

  // Drop the input valid and wait until every transaction has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (results_seen != sent_count) @(posedge clk);
  endtask

  // Apply all queued register writes while the pipeline is empty
  task automatic apply_config();
    reg_write_t w;
    settle();
    while (config_writes.size() != 0) begin
      w = config_writes.pop_front();
      cfg_write_en <= 1'b1;
      cfg_index    <= w.index;
      cfg_data     <= w.data;
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
  endtask

  // Present one transaction, with an optional idle burst ahead of it
  task automatic send_vector(mvt_in_t item, logic typed, mvt_out_t result);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= item;
    result_typed <= typed;
    typed_result <= result;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic check_lane(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endtask

  // Predict on input acceptance, track register writes, check results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_results.push_back(result_typed ? typed_result : transform_vector(in_data));
      if (cfg_write_en && cfg_index < NUM_REGS)
        matrix_words[cfg_index[REG_SEL_W-1:0]] = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with none pending");
          error_count++;
        end else begin
          head = expected_results.pop_front();
          check_lane("x_out", head.x_out, out_data.x_out);
          check_lane("y_out", head.y_out, out_data.y_out);
          check_lane("z_out", head.z_out, out_data.z_out);
          check_lane("w_out", head.w_out, out_data.w_out);
          check_lane("saturated", 32'(head.saturated), 32'(out_data.saturated));
          results_seen++;
        end
      end
    end
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output stall: random bursts, none in the steady tail
  initial begin
    logic hold;
    int   span;
    @(posedge clk);
    forever begin
      if (steady) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        hold = ($urandom_range(0, 2) == 0);
        span = $urandom_range(1, 15);
        out_stall <= hold;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    directed_step_t step;
    mvt_in_t        item;
    value_mix_e     matrix_mix;
    value_mix_e     vec_mix;
    for (int i = 0; i < NUM_REGS; i++) matrix_words[i] = '0;
    build_directed();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[k]) begin
      step = directed_steps[k];
      case (step.kind)
        STEP_MATRIX: begin
          for (int i = 0; i < NUM_REGS; i++)
            queue_write(i, matrix_word(i, step.data[63:32], step.data[31:0]));
        end
        STEP_WRITE: begin
          queue_write(step.index, step.data);
        end
        default: begin
          if (config_writes.size() != 0) apply_config();
          send_vector(step.item, step.typed, step.result);
        end
      endcase
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      matrix_mix = value_mix_e'(p % 4);
      for (int i = 0; i < NUM_REGS; i++)
        queue_write(i, {rand_element(matrix_mix), rand_element(matrix_mix)});
      if ($urandom_range(0, 1) == 1)
        queue_write($urandom_range(NUM_REGS, REG_INDEX_TOP), {$urandom(), $urandom()});
      apply_config();
      // Last phase runs back to back on both sides
      steady = (p == RANDOM_PHASES - 1);
      repeat (PHASE_ITEMS) begin
        vec_mix     = value_mix_e'($urandom_range(0, 3));
        item.action = ($urandom_range(0, 1) == 1) ? ACTION_ROW : ACTION_COLUMN;
        item.x_in   = rand_element(vec_mix);
        item.y_in   = rand_element(vec_mix);
        item.z_in   = rand_element(vec_mix);
        item.w_in   = rand_element(vec_mix);
        send_vector(item, 1'b0, '0);
      end
    end

    settle();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
